// ===== rtl/core/mrr_pkg.sv =====
// mrr_pkg: shared types, codes and the crc-16 byte update for the modbus rtu
// response receiver. No dependencies; every other file in rtl/core imports it.
`default_nettype none

package mrr_pkg;

   localparam int unsigned ADDR_W     = 3;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned CNT_W      = 9;

   // register byte addresses
   localparam logic [ADDR_W-1:0] REG_SLAVE_ADDRESS = 3'd0;

   // request function codes
   localparam logic [1:0] FUNC_START   = 2'd0;
   localparam logic [1:0] FUNC_BYTE    = 2'd1;
   localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

   // result status codes
   localparam logic [2:0] ST_RECEIVING = 3'd0;
   localparam logic [2:0] ST_OK        = 3'd1;
   localparam logic [2:0] ST_TIMEOUT   = 3'd2;
   localparam logic [2:0] ST_SLAVE     = 3'd3;
   localparam logic [2:0] ST_CRC       = 3'd4;
   localparam logic [2:0] ST_EXC       = 3'd5;

   localparam logic [15:0]      CRC_INIT    = 16'hFFFF;
   localparam logic [15:0]      CRC_POLY    = 16'hA001;
   localparam logic [7:0]       EXC_FLAG    = 8'h80;
   localparam logic [7:0]       FC_READ_LO  = 8'h01;
   localparam logic [7:0]       FC_READ_HI  = 8'h04;
   localparam logic [7:0]       FC_WR_COIL  = 8'h05;
   localparam logic [7:0]       FC_WR_REG   = 8'h06;
   localparam logic [7:0]       FC_WR_COILS = 8'h0F;
   localparam logic [7:0]       FC_WR_REGS  = 8'h10;
   localparam logic [CNT_W-1:0] MAX_FRAME   = 9'd260;
   localparam logic [7:0]       SLAVE_RESET = 8'h01;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RECV = 2'd1,
      PH_DONE = 2'd2
   } mrr_phase_type;

   typedef struct packed {
      mrr_phase_type    phase;
      logic [CNT_W-1:0] count;
      logic [15:0]      crc;
      logic [7:0]       first_byte;
      logic [7:0]       func_code;
      logic [7:0]       third_byte;
   } mrr_state_type;

   typedef struct packed {
      logic [7:0]       byte_out;
      logic [CNT_W-1:0] byte_index;
      logic             done_res;
      logic [2:0]       status;
      logic [7:0]       function_code;
      logic [7:0]       exception_code;
      logic [CNT_W-1:0] frame_length;
   } mrr_rsp_type;

   localparam mrr_state_type STATE_CLEAR = '{
      phase:      PH_IDLE,
      count:      '0,
      crc:        CRC_INIT,
      first_byte: 8'h00,
      func_code:  8'h00,
      third_byte: 8'h00
   };

   // reflected crc-16, one byte, bit steps unrolled
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mrr_ifs.sv =====
// mrr_req_if and mrr_rsp_if: valid/ready channels of the response receiver.
// Depends on mrr_pkg for field widths.
`default_nettype none

interface mrr_req_if;
   import mrr_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface mrr_rsp_if;
   import mrr_pkg::*;
   logic             valid;
   logic             ready;
   logic [7:0]       byte_out;
   logic [CNT_W-1:0] byte_index;
   logic             done_res;
   logic [2:0]       status;
   logic [7:0]       function_code;
   logic [7:0]       exception_code;
   logic [CNT_W-1:0] frame_length;

   modport source (output valid, output byte_out, output byte_index, output done_res,
                   output status, output function_code, output exception_code,
                   output frame_length, input ready);
   modport sink   (input valid, input byte_out, input byte_index, input done_res,
                   input status, input function_code, input exception_code,
                   input frame_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mrr_csr.sv =====
// mrr_csr: apb-style register block holding the expected slave address.
// Depends on mrr_pkg.
`default_nettype none

module mrr_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [mrr_pkg::ADDR_W-1:0] paddr,
   input  wire logic [mrr_pkg::DATA_W-1:0] pwdata,
   output      logic [mrr_pkg::DATA_W-1:0] prdata,
   output      logic                       pready,
   output      logic [7:0]                 slave_address
);
   import mrr_pkg::*;

   logic [7:0] slave_ff;
   logic [7:0] slave_in;
   logic       hit;

   // registers sit on 4-byte boundaries, low bits ignored
   assign hit = (paddr[ADDR_W-1:2] == REG_SLAVE_ADDRESS[ADDR_W-1:2]);

   always_comb begin
      slave_in = slave_ff;
      if (psel && penable && pwrite && hit) begin
         slave_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff <= SLAVE_RESET;
      end else begin
         slave_ff <= slave_in;
      end
   end

   assign pready        = 1'b1;
   assign prdata        = hit ? {{(DATA_W-8){1'b0}}, slave_ff} : '0;
   assign slave_address = slave_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mrr_step.sv =====
// mrr_step: combinational frame update for one request: crc, length decode,
// final status and the result fields. Depends on mrr_pkg.
`default_nettype none

module mrr_step (
   input  wire logic                  [1:0] func,
   input  wire logic                  [7:0] rx_byte,
   input  wire logic                  [7:0] slave_address,
   input  wire mrr_pkg::mrr_state_type      state_cur,
   output      mrr_pkg::mrr_state_type      state_nxt,
   output      logic                        res_valid,
   output      mrr_pkg::mrr_rsp_type        res
);
   import mrr_pkg::*;

   mrr_state_type upd;
   logic [9:0]    exp_len;
   logic          frame_done;
   logic [2:0]    st_timeout;
   logic [2:0]    st_byte;

   function automatic logic [2:0] final_status(input mrr_state_type s, input logic [7:0] slv);
      logic [2:0] st;
      if (s.count < 9'd2) st = ST_TIMEOUT;
      else if (s.first_byte != slv) st = ST_SLAVE;
      else if (s.count < 9'd4 || s.crc != 16'h0000) st = ST_CRC;
      else if ((s.func_code & EXC_FLAG) != 8'h00) st = ST_EXC;
      else st = ST_OK;
      return st;
   endfunction

   function automatic mrr_rsp_type fill(input mrr_state_type s, input logic [7:0] b,
                                        input logic [CNT_W-1:0] idx, input logic done,
                                        input logic [2:0] st);
      mrr_rsp_type r;
      r.byte_out       = b;
      r.byte_index     = idx;
      r.done_res       = done;
      r.status         = st;
      r.function_code  = (s.count >= 9'd2) ? s.func_code : 8'h00;
      r.exception_code = (((s.func_code & EXC_FLAG) != 8'h00) && s.count >= 9'd5)
                         ? s.third_byte : 8'h00;
      r.frame_length   = s.count;
      return r;
   endfunction

   // state after taking rx_byte
   always_comb begin
      upd       = state_cur;
      upd.phase = PH_RECV;
      upd.count = state_cur.count + 9'd1;
      upd.crc   = crc16_byte(state_cur.crc, rx_byte);
      if (state_cur.count == 9'd0) upd.first_byte = rx_byte;
      if (state_cur.count == 9'd1) upd.func_code  = rx_byte;
      if (state_cur.count == 9'd2) upd.third_byte = rx_byte;
   end

   // expected length, zero when the code gives none
   always_comb begin
      exp_len = 10'd0;
      if (upd.count >= 9'd2) begin
         if ((upd.func_code & EXC_FLAG) != 8'h00) begin
            exp_len = 10'd5;
         end else if (upd.func_code >= FC_READ_LO && upd.func_code <= FC_READ_HI) begin
            exp_len = 10'd5 + ((upd.count > 9'd2) ? {2'b00, upd.third_byte} : 10'd0);
         end else if (upd.func_code == FC_WR_COIL || upd.func_code == FC_WR_REG ||
                      upd.func_code == FC_WR_COILS || upd.func_code == FC_WR_REGS) begin
            exp_len = 10'd8;
         end
      end
   end

   assign frame_done = (exp_len != 10'd0) && ({1'b0, upd.count} >= exp_len);
   assign st_timeout = final_status(state_cur, slave_address);
   assign st_byte    = frame_done ? final_status(upd, slave_address) : ST_RECEIVING;

   always_comb begin
      state_nxt = state_cur;
      res_valid = 1'b0;
      res       = fill(upd, rx_byte, state_cur.count, frame_done, st_byte);
      case (func)
         FUNC_START: begin
            state_nxt = STATE_CLEAR;
         end
         FUNC_BYTE: begin
            if (state_cur.phase != PH_DONE && state_cur.count < MAX_FRAME) begin
               state_nxt = upd;
               if (frame_done) state_nxt.phase = PH_DONE;
               res_valid = 1'b1;
            end
         end
         FUNC_TIMEOUT: begin
            if (state_cur.phase != PH_DONE) begin
               state_nxt.phase = PH_DONE;
               res_valid       = 1'b1;
               res             = fill(state_cur, 8'h00, '0, 1'b1, st_timeout);
            end
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/modbus_rtu_response_receiver_unit.sv =====
// Modbus rtu response receiver: one request per cycle, each byte or timeout
// answered from a single result register in the cycle after its transfer, while
// the frame state (count, crc-16, header bytes) updates in the same cycle. The
// request side keeps accepting as long as the result register is empty or is
// being taken; a stalled result holds back only the next request. Start and
// dropped requests give no result. Depends on mrr_pkg, mrr_ifs, mrr_csr, mrr_step.
`default_nettype none

module modbus_rtu_response_receiver_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   mrr_req_if.sink                         req_chan,
   mrr_rsp_if.source                       rsp_chan,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [mrr_pkg::ADDR_W-1:0] paddr,
   input  wire logic [mrr_pkg::DATA_W-1:0] pwdata,
   output      logic [mrr_pkg::DATA_W-1:0] prdata,
   output      logic                       pready
);
   import mrr_pkg::*;

   logic          [7:0] slave_address;
   mrr_state_type       state_ff;
   mrr_state_type       state_in;
   mrr_state_type       state_nxt;
   mrr_rsp_type         res;
   logic                res_valid;
   mrr_rsp_type         rsp_ff;
   mrr_rsp_type         rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                accept;

   mrr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .slave_address (slave_address)
   );

   mrr_step u_step (
      .func          (req_chan.func),
      .rx_byte       (req_chan.rx_byte),
      .slave_address (slave_address),
      .state_cur     (state_ff),
      .state_nxt     (state_nxt),
      .res_valid     (res_valid),
      .res           (res)
   );

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in     = accept ? state_nxt : state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (accept && res_valid) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload needs no reset
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.byte_out       = rsp_ff.byte_out;
   assign rsp_chan.byte_index     = rsp_ff.byte_index;
   assign rsp_chan.done_res       = rsp_ff.done_res;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.function_code  = rsp_ff.function_code;
   assign rsp_chan.exception_code = rsp_ff.exception_code;
   assign rsp_chan.frame_length   = rsp_ff.frame_length;

   // a finished frame answers nothing until the next start
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.phase == PH_DONE && req_chan.func != FUNC_START
       && rsp_chan.ready) |=> !rsp_chan.valid)
      else $error("result produced after frame completion");

   // status is final exactly on a done result
   a_done_status: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.done_res == (rsp_chan.status != ST_RECEIVING)))
      else $error("done flag and status disagree");

   // a byte echo reports a length one past its index
   a_byte_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.done_res)
      |-> (rsp_chan.frame_length == rsp_chan.byte_index + 9'd1))
      else $error("frame length does not follow byte index");

   // a start transfer always leaves a cleared crc and count
   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.func == FUNC_START)
      |=> (state_ff.crc == CRC_INIT && state_ff.count == '0))
      else $error("start did not clear frame state");

endmodule

`default_nettype wire
